FILE: rtl/core/upc_pkg.sv
// shared types, constants and character helpers for the percent codec
package upc_pkg;

	localparam int UPC_QUEUE_DEPTH = 2;
	localparam int UPC_MAX_BYTES   = 3;

	localparam logic [7:0] PCT_CHAR = 8'h25;

	typedef struct packed {
		logic [UPC_MAX_BYTES-1:0][7:0] data;
		logic [1:0]                    count;
		logic                          last;
	} upc_cmd_t;

	function automatic logic is_plain_byte(input logic [7:0] b);
		return (b inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39]}) ||
			b == 8'h2d || b == 8'h2e || b == 8'h5f || b == 8'h7e;
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] b);
		logic [7:0] v;
		v = 8'h00;
		if (b inside {[8'h30:8'h39]}) begin
			v = b - 8'h30;
		end else if (b inside {[8'h61:8'h66]}) begin
			v = b - 8'h57;
		end else begin
			v = b - 8'h37;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] hex_upper(input logic [3:0] n);
		logic [7:0] r;
		case (n)
			4'h0: r = 8'h30;
			4'h1: r = 8'h31;
			4'h2: r = 8'h32;
			4'h3: r = 8'h33;
			4'h4: r = 8'h34;
			4'h5: r = 8'h35;
			4'h6: r = 8'h36;
			4'h7: r = 8'h37;
			4'h8: r = 8'h38;
			4'h9: r = 8'h39;
			4'ha: r = 8'h41;
			4'hb: r = 8'h42;
			4'hc: r = 8'h43;
			4'hd: r = 8'h44;
			4'he: r = 8'h45;
			default: r = 8'h46;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/upc_front.sv
// front end: accepts bytes, tracks decode escape state, builds output commands
module upc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              full,
	output logic              push,
	output upc_pkg::upc_cmd_t push_cmd
);
	import upc_pkg::*;

	localparam logic [1:0] PH_NONE  = 2'd0;
	localparam logic [1:0] PH_PCT   = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;

	logic       direction_q;
	logic [1:0] phase_q;
	logic [7:0] held_q;
	logic [1:0] phase_d;
	logic [7:0] held_d;
	logic [1:0] n;
	logic       rescan;
	logic       take;

	assign in_ready = !full;
	assign take     = in_valid && in_ready;

	always_comb begin
		push_cmd = '0;
		n        = 2'd0;
		rescan   = 1'b0;
		phase_d  = PH_NONE;
		held_d   = 8'h00;
		if (!direction_q) begin
			if (is_plain_byte(in_byte)) begin
				push_cmd.data[0] = in_byte;
				n = 2'd1;
			end else begin
				push_cmd.data[0] = PCT_CHAR;
				push_cmd.data[1] = hex_upper(in_byte[7:4]);
				push_cmd.data[2] = hex_upper(in_byte[3:0]);
				n = 2'd3;
			end
		end else begin
			case (phase_q)
				PH_PCT: begin
					if (is_hex(in_byte)) begin
						phase_d = PH_DIGIT;
						held_d  = in_byte;
					end else begin
						push_cmd.data[n] = PCT_CHAR;
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				PH_DIGIT: begin
					// held byte is always a hex digit here
					if (is_hex(in_byte)) begin
						push_cmd.data[n] = {nibble_of(held_q), nibble_of(in_byte)};
						n = n + 2'd1;
					end else begin
						push_cmd.data[n] = PCT_CHAR;
						n = n + 2'd1;
						push_cmd.data[n] = held_q;
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				default: begin
					rescan = 1'b1;
				end
			endcase
			if (rescan) begin
				if (in_byte == PCT_CHAR) begin
					phase_d = PH_PCT;
				end else begin
					push_cmd.data[n] = in_byte;
					n = n + 2'd1;
				end
			end
			// end of string flushes whatever escape is still open
			if (in_last) begin
				if (phase_d != PH_NONE) begin
					push_cmd.data[n] = PCT_CHAR;
					n = n + 2'd1;
				end
				if (phase_d == PH_DIGIT) begin
					push_cmd.data[n] = held_d;
					n = n + 2'd1;
				end
				phase_d = PH_NONE;
				held_d  = 8'h00;
			end
		end
		push_cmd.count = n;
		push_cmd.last  = in_last;
	end

	assign push = take && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			phase_q     <= PH_NONE;
			held_q      <= 8'h00;
		end else if (cfg_we) begin
			direction_q <= cfg_wdata;
			phase_q     <= PH_NONE;
			held_q      <= 8'h00;
		end else if (take) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

FILE: rtl/core/upc_queue.sv
// small register queue of commands between front and back
module upc_queue #(
	parameter int DEPTH = upc_pkg::UPC_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  upc_pkg::upc_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output upc_pkg::upc_cmd_t head_cmd
);
	import upc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	upc_cmd_t        slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full       = cnt_q == FULL_CNT;
	assign head_valid = cnt_q != '0;
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/upc_back.sv
// back end: walks the bytes of each command into the output register
module upc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  upc_pkg::upc_cmd_t head_cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              run_last,
	output logic              string_last
);
	import upc_pkg::*;

	logic [1:0] idx_q;
	logic       load;
	logic       fin;

	assign load = head_valid && (!out_valid || out_ready);
	assign fin  = idx_q == (head_cmd.count - 2'd1);
	assign pop  = load && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				idx_q     <= fin ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte    <= head_cmd.data[idx_q];
			run_last    <= fin;
			string_last <= fin && head_cmd.last;
		end
	end

endmodule

FILE: rtl/core/url_percent_codec_top.sv
// top level of the percent codec: front end, command queue and back end
// an accepted item goes into the command queue, then its first byte into the output register
// throughput: one item per cycle while each gives one byte and out_ready stays high;
// an item that gives more bytes, at most three, holds the output register until all have left
// decode items that only extend an escape push no command and give no transfer
// reset clears direction to encode, the escape state, the queue and out_valid
module url_percent_codec_top #(
	parameter int QUEUE_DEPTH = upc_pkg::UPC_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_last
);
	import upc_pkg::*;

	logic     push;
	upc_cmd_t push_cmd;
	logic     full;
	logic     pop;
	logic     head_valid;
	upc_cmd_t head_cmd;

	upc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	upc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	upc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_last(string_last)
	);

endmodule

FILE: rtl/core/upc_checker.sv
// port-level checks for the percent codec, bound to the top level
module upc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       string_last
);

	// a stalled output transfer holds its byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("output byte changed while stalled");

	// end of string only on the final byte of an item
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_last |-> run_last)
		else $error("string_last without run_last");

	// bytes of one item leave without gaps
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("gap inside one item's output bytes");

	// nothing is shown right after reset release
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("out_valid high after reset");

endmodule

bind url_percent_codec_top upc_checker u_chk (.*);
